>>> hdl/rhs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Return-home sequencer package
// Shared codes, constants and the command/status structs that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rhs_pkg;

   // Operation codes carried by a request beat.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // Phase codes.
   localparam logic [3:0] PH_JUMP   = 4'd0;
   localparam logic [3:0] PH_HOVER  = 4'd1;
   localparam logic [3:0] PH_DECIDE = 4'd2;
   localparam logic [3:0] PH_CLIMB  = 4'd3;
   localparam logic [3:0] PH_GOHOME = 4'd4;
   localparam logic [3:0] PH_ARRIVE = 4'd5;
   localparam logic [3:0] PH_PAUSE  = 4'd6;
   localparam logic [3:0] PH_FAST   = 4'd7;
   localparam logic [3:0] PH_SLOW   = 4'd8;

   // Register map of the control port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_LIFT_HEIGHT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWEST_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOVER_TIME    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_HEIGHT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCURACY_XY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCURACY_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HOVER_AT_HOME = 3'd6;

   // Register reset values.
   localparam logic [19:0]        RST_LIFT_HEIGHT   = 20'd20000;
   localparam logic signed [17:0] RST_LOWEST_HEIGHT = 18'sd0;
   localparam logic [16:0]        RST_HOVER_TIME    = 17'd20000;
   localparam logic [19:0]        RST_FAST_HEIGHT   = 20'd5000;
   localparam logic [15:0]        RST_ACCURACY_XY   = 16'd2000;
   localparam logic [15:0]        RST_ACCURACY_Z    = 16'd1000;
   localparam logic               RST_HOVER_AT_HOME = 1'b1;

   // Sequencer constants.
   localparam logic [16:0]        TIMER_MAX          = 17'd131071;
   localparam logic [16:0]        SHORT_HOVER_MS     = 17'd4000;
   localparam logic [16:0]        PAUSE_MS           = 17'd5000;
   localparam logic [16:0]        NEAR_HOME_TIMER_MS = 17'd6000;
   localparam logic signed [21:0] JUMP_ALT_MM        = 22'sd3000;
   localparam logic signed [21:0] SLOW_MIN_ALT_MM    = 22'sd2000;

   // Fixed-point limits of the target and of the reported altitude.
   localparam logic signed [31:0] FX_MAX  = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] FX_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] OUT_MAX = 32'sd2097151;
   localparam logic signed [31:0] OUT_MIN = -32'sd2097152;

   // Slow descent divides by 20000 = 625 * 32. The 625 part uses a
   // reciprocal floor(2^40 / 625) and one correction step.
   localparam logic [30:0] RECIP_625   = 31'd1759218604;
   localparam int          RECIP_SHIFT = 40;
   localparam logic [31:0] DIV_625     = 32'd625;
   localparam logic [10:0] DIV_625_11  = 11'd625;
   localparam int          DIV_32_SHIFT = 5;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV1,
      ST_REM1,
      ST_DIV2,
      ST_REM2,
      ST_DONE
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // Register the request beat.
      logic exec;      // Apply the phase rules.
      logic div;       // Reciprocal multiply of the dividend.
      logic rem1;      // Correct first quotient, form second dividend.
      logic rem2;      // Correct second quotient, apply the descent step.
      logic load_out;  // Load the response register.
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slow_needed;  // This beat needs the descent-rate divide.
      logic out_free;     // The response register can take a new beat.
   } dp_status_type;

endpackage
`default_nettype wire

>>> hdl/rhs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Return-home sequencer controller
// State machine that captures a request beat, steps the datapath through the
// phase update and the descent-rate divide, and hands off the response.
// ----------------------------------------------------------------------------
module rhs_ctrl
   import rhs_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   input  wire           req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = status.slow_needed ? ST_DIV1 : ST_DONE;
         end
         ST_DIV1: state_in = ST_REM1;
         ST_REM1: state_in = ST_DIV2;
         ST_DIV2: state_in = ST_REM2;
         ST_REM2: state_in = ST_DONE;
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs. No request beat is taken while reset is held.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = reset;
            cmd.capture = req_valid && !reset;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_DIV1: cmd.div  = 1'b1;
         ST_REM1: cmd.rem1 = 1'b1;
         ST_DIV2: cmd.div  = 1'b1;
         ST_REM2: cmd.rem2 = 1'b1;
         ST_DONE: cmd.load_out = status.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> hdl/rhs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Return-home sequencer datapath
// Control registers, request capture, sequencer state, phase rules, the
// shared reciprocal divider for the descent rate and the response register.
// ----------------------------------------------------------------------------
module rhs_datapath
   import rhs_pkg::*;
#(
   parameter int FRAC_BITS = 8
)
(
   input  wire                          clock,
   input  wire                          reset,
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                status,
   input  wire                          csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]         csr_index,
   input  wire  [CSR_DATA_W-1:0]        csr_wr_data,
   input  wire  [1:0]                   req_op,
   input  wire  signed [21:0]           req_altitude_mm,
   input  wire  signed [23:0]           req_dx_home_mm,
   input  wire  signed [23:0]           req_dy_home_mm,
   input  wire  [15:0]                  req_gps_accuracy_mm,
   input  wire  [9:0]                   req_dt_ms,
   input  wire                          rsp_stall,
   output logic                         rsp_valid,
   output logic signed [21:0]           rsp_target_altitude_mm,
   output logic [3:0]                   rsp_phase,
   output logic                         rsp_active,
   output logic                         rsp_steer_home,
   output logic                         rsp_hold_position
);

   // Width of the measured altitude in fixed point, and of the working
   // arithmetic with headroom for a difference and its magnitude.
   localparam int AFW  = 22 + FRAC_BITS;
   localparam int WW   = ((AFW > 32) ? AFW : 32) + 2;
   localparam int DECW = 22 + FRAC_BITS;

   function automatic logic signed [31:0] sat_fx(input logic signed [WW-1:0] v);
      logic signed [31:0] r;
      if (v > WW'(FX_MAX)) r = FX_MAX;
      else if (v < WW'(FX_MIN)) r = FX_MIN;
      else r = v[31:0];
      return r;
   endfunction

   // Control registers.
   logic [19:0]        lift_ff,    lift_in;
   logic signed [17:0] lowest_ff,  lowest_in;
   logic [16:0]        hover_ff,   hover_in;
   logic [19:0]        fast_ff,    fast_in;
   logic [15:0]        accxy_ff,   accxy_in;
   logic [15:0]        accz_ff,    accz_in;
   logic               hah_ff,     hah_in;

   // Captured request beat.
   logic [1:0]         op_ff;
   logic signed [21:0] alt_ff;
   logic signed [23:0] dx_ff;
   logic signed [23:0] dy_ff;
   logic [15:0]        gacc_ff;
   logic [9:0]         dt_ff;

   // Sequencer state.
   logic [3:0]         phase_ff,   phase_in;
   logic [16:0]        timer_ff,   timer_in;
   logic signed [31:0] target_ff,  target_in;
   logic               running_ff, running_in;
   logic               steer_ff,   steer_in;
   logic               hold_ff,    hold_in;

   // Divider registers.
   logic [30:0]        num_ff,     num_in;
   logic [61:0]        mult_ff,    mult_in;
   logic [21:0]        q1_ff,      q1_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [21:0] rsp_alt_ff;
   logic [3:0]         rsp_phase_ff;
   logic               rsp_active_ff;
   logic               rsp_steer_ff;
   logic               rsp_hold_ff;

   // Derived values.
   logic signed [WW-1:0] alt_fx_w;
   logic signed [WW-1:0] alt_err;
   logic signed [WW-1:0] alt_err_abs;
   logic signed [WW-1:0] tol_z;
   logic signed [31:0]   jump_fx;
   logic signed [31:0]   lift_fx;
   logic signed [31:0]   fast_fx;
   logic signed [31:0]   lowest_fx;
   logic signed [31:0]   start_fx;
   logic signed [24:0]   dx_ext;
   logic signed [24:0]   dy_ext;
   logic [24:0]          dx_abs;
   logic [24:0]          dy_abs;
   logic [16:0]          acc_xy;
   logic                 near_home;
   logic [17:0]          timer_sum;
   logic [16:0]          timer_add;
   logic [16:0]          hover_lim;
   logic                 below_fast;
   logic                 above_low;
   logic [20:0]          rate_alt;
   logic [30:0]          prod_p;
   logic [21:0]          q_est;
   logic [31:0]          rem_raw;
   logic [10:0]          rem_lo;
   logic [21:0]          q_corr;
   logic [9:0]           r_corr;
   logic [DECW-1:0]      dec_sum;
   logic [DECW-1:0]      dec_val;
   logic signed [31:0]   slow_target;
   logic signed [31:0]   tmm;

   // Control register writes.
   always_comb begin
      lift_in   = lift_ff;
      lowest_in = lowest_ff;
      hover_in  = hover_ff;
      fast_in   = fast_ff;
      accxy_in  = accxy_ff;
      accz_in   = accz_ff;
      hah_in    = hah_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LIFT_HEIGHT:   lift_in   = csr_wr_data;
            CSR_LOWEST_HEIGHT: lowest_in = csr_wr_data[17:0];
            CSR_HOVER_TIME:    hover_in  = csr_wr_data[16:0];
            CSR_FAST_HEIGHT:   fast_in   = csr_wr_data;
            CSR_ACCURACY_XY:   accxy_in  = csr_wr_data[15:0];
            CSR_ACCURACY_Z:    accz_in   = csr_wr_data[15:0];
            CSR_HOVER_AT_HOME: hah_in    = csr_wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff   <= RST_LIFT_HEIGHT;
         lowest_ff <= RST_LOWEST_HEIGHT;
         hover_ff  <= RST_HOVER_TIME;
         fast_ff   <= RST_FAST_HEIGHT;
         accxy_ff  <= RST_ACCURACY_XY;
         accz_ff   <= RST_ACCURACY_Z;
         hah_ff    <= RST_HOVER_AT_HOME;
      end else begin
         lift_ff   <= lift_in;
         lowest_ff <= lowest_in;
         hover_ff  <= hover_in;
         fast_ff   <= fast_in;
         accxy_ff  <= accxy_in;
         accz_ff   <= accz_in;
         hah_ff    <= hah_in;
      end
   end

   // Fixed-point forms of the altitude and the heights.
   assign alt_fx_w    = WW'(alt_ff) <<< FRAC_BITS;
   assign alt_err     = alt_fx_w - WW'(target_ff);
   assign alt_err_abs = (alt_err < 0) ? -alt_err : alt_err;
   assign tol_z       = $signed(WW'(accz_ff)) <<< FRAC_BITS;
   assign jump_fx     = sat_fx(WW'(JUMP_ALT_MM) <<< FRAC_BITS);
   assign lift_fx     = sat_fx($signed(WW'(lift_ff)) <<< FRAC_BITS);
   assign fast_fx     = sat_fx($signed(WW'(fast_ff)) <<< FRAC_BITS);
   assign lowest_fx   = sat_fx(WW'(lowest_ff) <<< FRAC_BITS);
   assign start_fx    = sat_fx(alt_fx_w);

   // Horizontal arrival check against the combined tolerance.
   assign dx_ext    = 25'(dx_ff);
   assign dy_ext    = 25'(dy_ff);
   assign dx_abs    = (dx_ext < 0) ? 25'(-dx_ext) : 25'(dx_ext);
   assign dy_abs    = (dy_ext < 0) ? 25'(-dy_ext) : 25'(dy_ext);
   assign acc_xy    = 17'(accxy_ff) + 17'(gacc_ff);
   assign near_home = (dx_abs <= 25'(acc_xy)) && (dy_abs <= 25'(acc_xy));

   // Phase timer with saturation.
   assign timer_sum = 18'(timer_ff) + 18'(dt_ff);
   assign timer_add = (timer_sum > 18'(TIMER_MAX)) ? TIMER_MAX : timer_sum[16:0];
   assign hover_lim = hah_ff ? hover_ff : SHORT_HOVER_MS;

   assign below_fast = 23'(alt_ff) <= $signed({3'b000, fast_ff});
   assign above_low  = alt_ff > 22'(lowest_ff);

   // Descent-rate product dt * max(alt, 2000).
   assign rate_alt = (alt_ff < SLOW_MIN_ALT_MM) ? SLOW_MIN_ALT_MM[20:0] : alt_ff[20:0];
   assign prod_p   = 31'(dt_ff) * 31'(rate_alt);

   // Quotient correction after the reciprocal multiply: the estimate is at
   // most one below the true quotient.
   assign q_est   = mult_ff[RECIP_SHIFT+21:RECIP_SHIFT];
   assign rem_raw = 32'(num_ff) - 32'(q_est) * DIV_625;
   assign rem_lo  = rem_raw[10:0];
   always_comb begin
      if (rem_lo >= DIV_625_11) begin
         q_corr = q_est + 22'd1;
         r_corr = 10'(rem_lo - DIV_625_11);
      end else begin
         q_corr = q_est;
         r_corr = rem_lo[9:0];
      end
   end

   // Step = floor((q1 * 2^FRAC_BITS + q2) / 32), the remainder below 625
   // cannot carry across a multiple of 32.
   assign dec_sum     = (DECW'(q1_ff) << FRAC_BITS) + DECW'(q_corr);
   assign dec_val     = dec_sum >> DIV_32_SHIFT;
   assign slow_target = sat_fx(WW'(target_ff) - $signed(WW'(dec_val)));

   // Next state of the sequencer and of the divider.
   always_comb begin
      phase_in   = phase_ff;
      timer_in   = timer_ff;
      target_in  = target_ff;
      running_in = running_ff;
      steer_in   = steer_ff;
      hold_in    = hold_ff;
      num_in     = num_ff;
      mult_in    = mult_ff;
      q1_in      = q1_ff;

      if (cmd.exec) begin
         steer_in = 1'b0;
         hold_in  = 1'b0;
         num_in   = prod_p;
         case (op_ff)
            OP_START: begin
               target_in  = start_fx;
               hold_in    = 1'b1;
               running_in = 1'b1;
               timer_in   = '0;
               phase_in   = PH_JUMP;
            end
            OP_STOP: begin
               if (running_ff) begin
                  running_in = 1'b0;
                  hold_in    = 1'b1;
               end
            end
            OP_TICK: begin
               if (running_ff) begin
                  case (phase_ff)
                     PH_JUMP: begin
                        if (alt_ff < JUMP_ALT_MM) target_in = jump_fx;
                        phase_in = PH_HOVER;
                     end
                     PH_HOVER: begin
                        timer_in = timer_add;
                        if (timer_add > hover_lim) phase_in = PH_DECIDE;
                     end
                     PH_DECIDE: begin
                        if (near_home) begin
                           timer_in = NEAR_HOME_TIMER_MS;
                           phase_in = below_fast ? PH_SLOW : PH_PAUSE;
                           steer_in = 1'b1;
                        end else begin
                           target_in = lift_fx;
                           phase_in  = PH_CLIMB;
                        end
                     end
                     PH_CLIMB: begin
                        if (alt_err_abs <= tol_z) phase_in = PH_GOHOME;
                     end
                     PH_GOHOME: begin
                        steer_in = 1'b1;
                        phase_in = PH_ARRIVE;
                     end
                     PH_ARRIVE: begin
                        if (near_home) begin
                           phase_in = PH_PAUSE;
                           timer_in = '0;
                        end
                     end
                     PH_PAUSE: begin
                        timer_in = timer_add;
                        if (timer_add > PAUSE_MS) begin
                           phase_in  = PH_FAST;
                           target_in = fast_fx;
                        end
                     end
                     PH_FAST: begin
                        if (alt_err_abs < tol_z) phase_in = PH_SLOW;
                     end
                     PH_SLOW: begin
                        // Above the floor the step comes from the divider.
                        if (!above_low) target_in = lowest_fx;
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end

      if (cmd.div) begin
         mult_in = 62'(num_ff) * 62'(RECIP_625);
      end
      if (cmd.rem1) begin
         q1_in  = q_corr;
         num_in = 31'(r_corr) << FRAC_BITS;
      end
      if (cmd.rem2) begin
         target_in = slow_target;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_JUMP;
         timer_ff   <= '0;
         target_ff  <= '0;
         running_ff <= 1'b0;
         steer_ff   <= 1'b0;
         hold_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         timer_ff   <= timer_in;
         target_ff  <= target_in;
         running_ff <= running_in;
         steer_ff   <= steer_in;
         hold_ff    <= hold_in;
      end
   end

   // Request capture and divider operands.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         alt_ff  <= req_altitude_mm;
         dx_ff   <= req_dx_home_mm;
         dy_ff   <= req_dy_home_mm;
         gacc_ff <= req_gps_accuracy_mm;
         dt_ff   <= req_dt_ms;
      end
      num_ff  <= num_in;
      mult_ff <= mult_in;
      q1_ff   <= q1_in;
   end

   assign status.slow_needed = running_ff && (op_ff == OP_TICK) &&
                               (phase_ff == PH_SLOW) && above_low;
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   // Reported altitude: floor to millimetres, clamped to the field range.
   assign tmm = target_ff >>> FRAC_BITS;

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (tmm > OUT_MAX) rsp_alt_ff <= OUT_MAX[21:0];
         else if (tmm < OUT_MIN) rsp_alt_ff <= OUT_MIN[21:0];
         else rsp_alt_ff <= tmm[21:0];
         rsp_phase_ff  <= phase_ff;
         rsp_active_ff <= running_ff;
         rsp_steer_ff  <= steer_ff;
         rsp_hold_ff   <= hold_ff;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_target_altitude_mm = rsp_alt_ff;
   assign rsp_phase              = rsp_phase_ff;
   assign rsp_active             = rsp_active_ff;
   assign rsp_steer_home         = rsp_steer_ff;
   assign rsp_hold_position      = rsp_hold_ff;

endmodule
`default_nettype wire

>>> hdl/return_home_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Return-home sequencer core
// Nine-phase return-to-home sequencer for a multicopter in fixed point.
//
//   Channel  Direction  Handshake                 Carries
//   req      in         req_valid / req_stall     op, altitude, home offset,
//                                                 GPS accuracy, elapsed time
//   rsp      out        rsp_valid / rsp_stall     target altitude, phase, flags
//   csr      in         csr_wr_en                 register index and data
//
// A beat runs from acceptance through the execute state to the done state, where
// its response is loaded; a slow-descent tick above the floor also passes through
// two divide and two remainder states, which make two passes through the multiplier.
// The next beat is accepted once the response register is loaded, while that
// response may still wait to be taken; a stalled response holds the controller.
// Reset is synchronous, restores the register defaults and stalls the requests.
// ----------------------------------------------------------------------------
module return_home_sequencer_core
   import rhs_pkg::*;
#(
   parameter int FRAC_BITS = 8
)
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_wr_en,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wr_data,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [1:0]            req_op,
   input  wire  signed [21:0]    req_altitude_mm,
   input  wire  signed [23:0]    req_dx_home_mm,
   input  wire  signed [23:0]    req_dy_home_mm,
   input  wire  [15:0]           req_gps_accuracy_mm,
   input  wire  [9:0]            req_dt_ms,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic signed [21:0]    rsp_target_altitude_mm,
   output logic [3:0]            rsp_phase,
   output logic                  rsp_active,
   output logic                  rsp_steer_home,
   output logic                  rsp_hold_position
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing of one beat.
   rhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, phase rules, divider and response.
   rhs_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .req_op                 (req_op),
      .req_altitude_mm        (req_altitude_mm),
      .req_dx_home_mm         (req_dx_home_mm),
      .req_dy_home_mm         (req_dy_home_mm),
      .req_gps_accuracy_mm    (req_gps_accuracy_mm),
      .req_dt_ms              (req_dt_ms),
      .rsp_stall              (rsp_stall),
      .rsp_valid              (rsp_valid),
      .rsp_target_altitude_mm (rsp_target_altitude_mm),
      .rsp_phase              (rsp_phase),
      .rsp_active             (rsp_active),
      .rsp_steer_home         (rsp_steer_home),
      .rsp_hold_position      (rsp_hold_position)
   );

endmodule
`default_nettype wire

>>> hdl/rhs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Return-home sequencer checker
// Port-level properties of the response channel, bound to the core.
// ----------------------------------------------------------------------------
module rhs_checker
   import rhs_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_stall,
   input wire [3:0] rsp_phase,
   input wire       rsp_active,
   input wire       rsp_steer_home,
   input wire       rsp_hold_position
);

   // No response beat right after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A waiting response beat is not withdrawn.
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   // Steering home and latching the position never happen in the same step.
   a_steer_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_steer_home && rsp_hold_position))
      else $error("steer and hold both set");

   // Steering home only happens while the mode runs.
   a_steer_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_steer_home |-> rsp_active)
      else $error("steer while inactive");

   // A latch while running comes from a start, which restarts at the jump.
   a_start_jump: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hold_position && rsp_active |-> rsp_phase == PH_JUMP)
      else $error("start did not restart the sequence");

endmodule

bind return_home_sequencer_core rhs_checker u_rhs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_phase         (rsp_phase),
   .rsp_active        (rsp_active),
   .rsp_steer_home    (rsp_steer_home),
   .rsp_hold_position (rsp_hold_position)
);
`default_nettype wire
